// ===== rtl/core/triangle_overlap_2d_macros.svh =====
// ----------------------------------------------------------------------------
// triangle_overlap_2d assertion macros
// shared property shorthands for the checker, clocked on clock, reset high
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_OVERLAP_2D_MACROS_SVH
`define TRIANGLE_OVERLAP_2D_MACROS_SVH

// same-cycle implication
`define TOV_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("triangle_overlap_2d check failed");

// next-cycle implication
`define TOV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("triangle_overlap_2d check failed");

`endif

// ===== rtl/core/tov_pkg.sv =====
// ----------------------------------------------------------------------------
// tov_pkg
// shared constants and types of the triangle overlap pipeline
// ----------------------------------------------------------------------------
package tov_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int TOL_WIDTH       = 35;
   localparam int CSR_IDX_WIDTH   = 1;
   localparam int EDGE_COUNT      = 18;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TOLERANCE = 1'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TOUCH     = 1'd1;

   localparam logic [1:0] WIND_NONE = 2'd0;
   localparam logic [1:0] WIND_A    = 2'd1;
   localparam logic [1:0] WIND_B    = 2'd2;

   // per-stage load enables
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } tov_adv_type;

endpackage

// ===== rtl/core/tov_det.sv =====
// ----------------------------------------------------------------------------
// tov_det
// three-stage determinant (q-p) x (r-p): differences, products, subtract
// ----------------------------------------------------------------------------
module tov_det #(
   parameter int COORD_WIDTH = tov_pkg::COORD_WIDTH_DEF
) (
   input  logic                           clock,
   input  tov_pkg::tov_adv_type           adv,
   input  logic signed [COORD_WIDTH-1:0]  p_x,
   input  logic signed [COORD_WIDTH-1:0]  p_y,
   input  logic signed [COORD_WIDTH-1:0]  q_x,
   input  logic signed [COORD_WIDTH-1:0]  q_y,
   input  logic signed [COORD_WIDTH-1:0]  r_x,
   input  logic signed [COORD_WIDTH-1:0]  r_y,
   output logic signed [2*COORD_WIDTH+2:0] det
);
   import tov_pkg::*;

   localparam int DIF_W = COORD_WIDTH + 1;
   localparam int PRD_W = 2 * DIF_W;
   localparam int DET_W = PRD_W + 1;

   logic signed [DIF_W-1:0] dqx_ff, dqy_ff, drx_ff, dry_ff;
   logic signed [PRD_W-1:0] prd1_ff, prd2_ff;
   logic signed [DET_W-1:0] det_ff;

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         dqx_ff <= DIF_W'(q_x) - DIF_W'(p_x);
         dqy_ff <= DIF_W'(q_y) - DIF_W'(p_y);
         drx_ff <= DIF_W'(r_x) - DIF_W'(p_x);
         dry_ff <= DIF_W'(r_y) - DIF_W'(p_y);
      end
      if (adv.s2) begin
         prd1_ff <= PRD_W'(dqx_ff) * PRD_W'(dry_ff);
         prd2_ff <= PRD_W'(drx_ff) * PRD_W'(dqy_ff);
      end
      if (adv.s3) begin
         det_ff <= DET_W'(prd1_ff) - DET_W'(prd2_ff);
      end
   end

   assign det = det_ff;

endmodule

// ===== rtl/core/tov_decide.sv =====
// ----------------------------------------------------------------------------
// tov_decide
// edge-side compares against tolerance, then separation and winding result
// ----------------------------------------------------------------------------
module tov_decide #(
   parameter int DET_W = 2 * tov_pkg::COORD_WIDTH_DEF + 3
) (
   input  logic                                 clock,
   input  tov_pkg::tov_adv_type                 adv,
   input  logic signed [tov_pkg::TOL_WIDTH-1:0] tolerance,
   input  logic                                 touch_counts,
   input  logic signed [DET_W-1:0]              area_a,
   input  logic signed [DET_W-1:0]              area_b,
   input  logic signed [DET_W-1:0]              edge_det [tov_pkg::EDGE_COUNT],
   output logic                                 overlap,
   output logic [1:0]                           winding_error
);
   import tov_pkg::*;

   localparam int CMP_W = (DET_W > TOL_WIDTH) ? DET_W : TOL_WIDTH;

   logic [EDGE_COUNT-1:0] out_ff, out_in;
   logic                  neg_a_ff, neg_b_ff;
   logic                  overlap_ff, overlap_in;
   logic [1:0]            wind_ff, wind_in;
   logic                  sep;

   function automatic logic is_outside(input logic signed [DET_W-1:0] d,
                                       input logic signed [TOL_WIDTH-1:0] t,
                                       input logic touch);
      logic signed [CMP_W-1:0] de;
      logic signed [CMP_W-1:0] te;
      de = CMP_W'(d);
      te = CMP_W'(t);
      return touch ? (de < te) : !(te < de);
   endfunction

   always_comb begin
      for (int k = 0; k < EDGE_COUNT; k++) begin
         out_in[k] = is_outside(edge_det[k], tolerance, touch_counts);
      end
   end

   always_comb begin
      sep = 1'b0;
      for (int e = 0; e < EDGE_COUNT / 3; e++) begin
         sep = sep | (&out_ff[e*3 +: 3]);
      end
      if (neg_a_ff) begin
         wind_in = WIND_A;
      end else if (neg_b_ff) begin
         wind_in = WIND_B;
      end else begin
         wind_in = WIND_NONE;
      end
      overlap_in = !sep && !neg_a_ff && !neg_b_ff;
   end

   always_ff @(posedge clock) begin
      if (adv.s4) begin
         out_ff   <= out_in;
         neg_a_ff <= area_a[DET_W-1];
         neg_b_ff <= area_b[DET_W-1];
      end
      if (adv.s5) begin
         overlap_ff <= overlap_in;
         wind_ff    <= wind_in;
      end
   end

   assign overlap       = overlap_ff;
   assign winding_error = wind_ff;

endmodule

// ===== rtl/core/triangle_overlap_2d.sv =====
// ----------------------------------------------------------------------------
// triangle_overlap_2d
// 2d triangle pair overlap by separating edges, with winding check
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | req_a_x0 .. req_b_y2
//   rsp     | out       | rsp_valid / rsp_ready | rsp_overlap, rsp_winding_error
//   csr     | in        | csr_wr_en             | csr_index, csr_data
//
// one item per cycle while the output is not stalled; rsp_valid rises when the item reaches the result stage
// stages: differences, products, determinants, tolerance compares, result
// each stage holds while the one after it is full and stalled
// synchronous reset clears valid bits, tolerance to 0 and touch_counts to 1
// ----------------------------------------------------------------------------
module triangle_overlap_2d #(
   parameter int COORD_WIDTH = tov_pkg::COORD_WIDTH_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [COORD_WIDTH-1:0]            req_a_x0,
   input  logic signed [COORD_WIDTH-1:0]            req_a_y0,
   input  logic signed [COORD_WIDTH-1:0]            req_a_x1,
   input  logic signed [COORD_WIDTH-1:0]            req_a_y1,
   input  logic signed [COORD_WIDTH-1:0]            req_a_x2,
   input  logic signed [COORD_WIDTH-1:0]            req_a_y2,
   input  logic signed [COORD_WIDTH-1:0]            req_b_x0,
   input  logic signed [COORD_WIDTH-1:0]            req_b_y0,
   input  logic signed [COORD_WIDTH-1:0]            req_b_x1,
   input  logic signed [COORD_WIDTH-1:0]            req_b_y1,
   input  logic signed [COORD_WIDTH-1:0]            req_b_x2,
   input  logic signed [COORD_WIDTH-1:0]            req_b_y2,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic                                     rsp_overlap,
   output logic [1:0]                               rsp_winding_error,
   input  logic                                     csr_wr_en,
   input  logic [tov_pkg::CSR_IDX_WIDTH-1:0]        csr_index,
   input  logic [tov_pkg::TOL_WIDTH-1:0]            csr_data
);
   import tov_pkg::*;

   localparam int DET_W = 2 * COORD_WIDTH + 3;

   logic signed [TOL_WIDTH-1:0] tol_ff;
   logic                        touch_ff;
   logic [5:1]                  vld_ff, vld_in;
   tov_adv_type                 adv;

   logic signed [COORD_WIDTH-1:0] pt_x [2][3];
   logic signed [COORD_WIDTH-1:0] pt_y [2][3];
   logic signed [DET_W-1:0]       area_det [2];
   logic signed [DET_W-1:0]       edge_det [EDGE_COUNT];

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff   <= '0;
         touch_ff <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TOLERANCE: tol_ff   <= csr_data;
            CSR_TOUCH:     touch_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // stage advance, back to front
   always_comb begin
      adv.s5 = !vld_ff[5] || rsp_ready;
      adv.s4 = !vld_ff[4] || adv.s5;
      adv.s3 = !vld_ff[3] || adv.s4;
      adv.s2 = !vld_ff[2] || adv.s3;
      adv.s1 = !vld_ff[1] || adv.s2;
      vld_in[1] = adv.s1 ? req_valid : vld_ff[1];
      vld_in[2] = adv.s2 ? vld_ff[1] : vld_ff[2];
      vld_in[3] = adv.s3 ? vld_ff[2] : vld_ff[3];
      vld_in[4] = adv.s4 ? vld_ff[3] : vld_ff[4];
      vld_in[5] = adv.s5 ? vld_ff[4] : vld_ff[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = adv.s1;
   assign rsp_valid = vld_ff[5];

   always_comb begin
      pt_x[0][0] = req_a_x0;  pt_y[0][0] = req_a_y0;
      pt_x[0][1] = req_a_x1;  pt_y[0][1] = req_a_y1;
      pt_x[0][2] = req_a_x2;  pt_y[0][2] = req_a_y2;
      pt_x[1][0] = req_b_x0;  pt_y[1][0] = req_b_y0;
      pt_x[1][1] = req_b_x1;  pt_y[1][1] = req_b_y1;
      pt_x[1][2] = req_b_x2;  pt_y[1][2] = req_b_y2;
   end

   // signed area of each triangle
   for (genvar s = 0; s < 2; s++) begin : g_area
      tov_det #(.COORD_WIDTH(COORD_WIDTH)) u_area (
         .clock (clock),
         .adv   (adv),
         .p_x   (pt_x[s][0]), .p_y (pt_y[s][0]),
         .q_x   (pt_x[s][1]), .q_y (pt_y[s][1]),
         .r_x   (pt_x[s][2]), .r_y (pt_y[s][2]),
         .det   (area_det[s])
      );
   end

   // each edge of one triangle against each vertex of the other
   for (genvar s = 0; s < 2; s++) begin : g_side
      for (genvar e = 0; e < 3; e++) begin : g_edge
         for (genvar v = 0; v < 3; v++) begin : g_vtx
            tov_det #(.COORD_WIDTH(COORD_WIDTH)) u_edge (
               .clock (clock),
               .adv   (adv),
               .p_x   (pt_x[s][e]),           .p_y (pt_y[s][e]),
               .q_x   (pt_x[s][(e + 1) % 3]), .q_y (pt_y[s][(e + 1) % 3]),
               .r_x   (pt_x[1 - s][v]),       .r_y (pt_y[1 - s][v]),
               .det   (edge_det[s * 9 + e * 3 + v])
            );
         end
      end
   end

   tov_decide #(.DET_W(DET_W)) u_decide (
      .clock         (clock),
      .adv           (adv),
      .tolerance     (tol_ff),
      .touch_counts  (touch_ff),
      .area_a        (area_det[0]),
      .area_b        (area_det[1]),
      .edge_det      (edge_det),
      .overlap       (rsp_overlap),
      .winding_error (rsp_winding_error)
   );

endmodule

// ===== rtl/core/tov_checker.sv =====
// ----------------------------------------------------------------------------
// tov_checker
// port-level checks on the triangle overlap block, bound to the top level
// ----------------------------------------------------------------------------
`include "triangle_overlap_2d_macros.svh"

module tov_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_overlap,
   input logic [1:0] rsp_winding_error
);
   import tov_pkg::*;

   // a stalled item holds
   `TOV_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_overlap) && $stable(rsp_winding_error))

   // valid drops only after a taken item
   `TOV_ASSERT_NOW(a_rsp_drop, $fell(rsp_valid), $past(rsp_ready))

   // a winding error never reports overlap
   `TOV_ASSERT_NOW(a_err_no_overlap, rsp_valid && (rsp_winding_error != WIND_NONE), !rsp_overlap)

   // input backpressure only when the pipe is full and the output is stalled
   `TOV_ASSERT_NOW(a_ready_full, !req_ready, rsp_valid && !rsp_ready)

endmodule

bind triangle_overlap_2d tov_checker u_tov_checker (.*);
